// ===== hw/rtl/rtcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcd_pkg: shared types and constants of the radio time-code decoder
// Event and frame status codes, the held time record, the edge class record
// and the timing windows used to sort receiver edges.
// ----------------------------------------------------------------------------
package rtcd_pkg;

  // Number of data bits kept per minute frame
  localparam int STORE_BITS = 58;
  localparam int COUNT_W    = 6;
  localparam int COUNT_MAX  = 63;

  // Configuration register
  localparam int          CFG_W         = 16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

  // Pulse timing windows in milliseconds
  localparam int SEC_MIN  = 900;
  localparam int SEC_MAX  = 1100;
  localparam int MIN_MIN  = 1900;
  localparam int MIN_MAX  = 2100;
  localparam int ZERO_MIN = 70;
  localparam int ZERO_MAX = 130;
  localparam int ONE_MIN  = 170;
  localparam int ONE_MAX  = 230;

  // Calendar constants
  localparam int YEAR_BASE  = 2000;
  localparam int YEAR_RESET = 2017;

  // Output packing
  localparam int EVENT_W    = 3;
  localparam int STATUS_W   = 2;
  localparam int OUT_USER_W = EVENT_W + STATUS_W;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_INVALID = 3'd1,
    EV_ZERO    = 3'd2,
    EV_ONE     = 3'd3,
    EV_SECOND  = 3'd4,
    EV_MINUTE  = 3'd5
  } event_t;

  typedef enum logic [STATUS_W-1:0] {
    FS_NONE  = 2'd0,
    FS_OK    = 2'd1,
    FS_ERROR = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } held_time_t;

  typedef struct packed {
    event_t ev;
    logic   fall;
    logic   rise;
  } edge_class_t;

endpackage

// ===== hw/rtl/rtcd_edge_class.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcd_edge_class: receiver edge classifier
// Measures the time since the last falling edge and sorts the current
// sample into no event or an invalid, bit, second or minute-mark event.
// ----------------------------------------------------------------------------
module rtcd_edge_class #(
  parameter int TIME_BITS = 16
) (
  input  logic                       level,
  input  logic [TIME_BITS-1:0]       now,
  input  logic                       last_level,
  input  logic [TIME_BITS-1:0]       last_fall,
  input  logic [rtcd_pkg::CFG_W-1:0] timeout_ms,
  output rtcd_pkg::edge_class_t      cls
);
  import rtcd_pkg::*;

  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic [TIME_BITS-1:0] elapsed;
  logic [CMP_W-1:0]     el;
  logic [CMP_W-1:0]     tmo;

  // Elapsed time wraps with the time base.
  assign elapsed = now - last_fall;
  assign el      = CMP_W'(elapsed);
  assign tmo     = CMP_W'(timeout_ms);

  // Sort the sample by edge direction and pulse length.
  always_comb begin
    cls.fall = (level != last_level) && !level;
    cls.rise = (level != last_level) && level;
    cls.ev   = EV_NONE;
    if (level == last_level) begin
      if (el > tmo) cls.ev = EV_INVALID;
    end else if (!level) begin
      if (el >= CMP_W'(SEC_MIN) && el <= CMP_W'(SEC_MAX)) begin
        cls.ev = EV_SECOND;
      end else if (el >= CMP_W'(MIN_MIN) && el <= CMP_W'(MIN_MAX)) begin
        cls.ev = EV_MINUTE;
      end else begin
        cls.ev = EV_INVALID;
      end
    end else begin
      if (el >= CMP_W'(ZERO_MIN) && el <= CMP_W'(ZERO_MAX)) begin
        cls.ev = EV_ZERO;
      end else if (el >= CMP_W'(ONE_MIN) && el <= CMP_W'(ONE_MAX)) begin
        cls.ev = EV_ONE;
      end else begin
        cls.ev = EV_INVALID;
      end
    end
  end

endmodule

// ===== hw/rtl/rtcd_frame_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcd_frame_check: minute frame checker and BCD decoder
// Checks count, summer/winter bits, start bit and the three even parities,
// decodes the BCD time and date fields and range-checks them.
// ----------------------------------------------------------------------------
module rtcd_frame_check (
  input  logic [rtcd_pkg::STORE_BITS-1:0] bits,
  input  logic                            pending,
  input  logic [rtcd_pkg::COUNT_W-1:0]    count,
  output logic                            frame_ok,
  output rtcd_pkg::held_time_t            decoded
);
  import rtcd_pkg::*;

  // Two BCD digits to binary: units + 10 * tens.
  function automatic logic [7:0] bcd2bin(input logic [3:0] units, input logic [3:0] tens);
    bcd2bin = {4'd0, units} + {1'b0, tens, 3'd0} + {3'd0, tens, 1'b0};
  endfunction

  logic       hour_off;
  logic       dst_ok;
  logic [7:0] mi;
  logic [7:0] hr;
  logic [7:0] dy;
  logic [2:0] wd;
  logic [7:0] mo;
  logic [7:0] yr;

  // Winter time sets only the second flag; summer time only the first.
  assign hour_off = !bits[17] && bits[18];
  assign dst_ok   = bits[17] ^ bits[18];

  // Field decode.
  assign mi = bcd2bin(bits[24:21], {1'b0, bits[27:25]});
  assign hr = bcd2bin(bits[32:29], {2'b0, bits[34:33]}) + {7'd0, hour_off};
  assign dy = bcd2bin(bits[39:36], {2'b0, bits[41:40]});
  assign wd = bits[44:42];
  assign mo = bcd2bin(bits[48:45], {3'b0, bits[49]});
  assign yr = bcd2bin(bits[53:50], bits[57:54]);

  // All checks together decide whether the frame is taken.
  assign frame_ok = (count == COUNT_W'(STORE_BITS)) && dst_ok && bits[20]
                    && !(^bits[28:21]) && !(^bits[35:29])
                    && !((^bits[57:36]) ^ pending)
                    && (mi <= 8'd59) && (hr <= 8'd23)
                    && (dy != 8'd0) && (dy <= 8'd31) && (wd != 3'd0)
                    && (mo != 8'd0) && (mo <= 8'd12) && (yr <= 8'd99);

  assign decoded.minute  = mi[5:0];
  assign decoded.hour    = hr[4:0];
  assign decoded.day     = dy[4:0];
  assign decoded.weekday = wd;
  assign decoded.month   = mo[3:0];
  assign decoded.year    = 12'(YEAR_BASE) + {4'd0, yr};

endmodule

// ===== hw/rtl/radio_time_code_decoder.sv =====
`timescale 1ns / 1ps
// A sample waits in the input register until the master side is free and then
// moves on to the result register; the two registers are parted by the classify,
// frame-check and decode logic. Throughput: one sample per cycle while the
// master side takes every result.
// Reset (rst, synchronous): pipeline empty, timeout 3000 ms, bit count zero,
// held time Sunday 2017-01-01 00:00, all LEDs off. The bit store is not cleared.
// ----------------------------------------------------------------------------
// radio_time_code_decoder: minute-frame time-code decoder
// Classifies receiver edges, collects the 58 data bits of a minute, checks and
// decodes the frame on the minute mark and holds the last good time and LEDs.
// ----------------------------------------------------------------------------
module radio_time_code_decoder #(
  parameter int TIME_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Sample request. tdata: level [0], time_ms [TIME_BITS:1], zero padding.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [((TIME_BITS+8)/8)*8-1:0]  s_tdata,
  // Result request. tdata: minute, hour, day, weekday, month, year,
  // pulse_led, good_led, error_led, zero padding.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rtcd_pkg::OUT_DATA_W-1:0] m_tdata,
  // tuser: event_res [2:0], frame_status [4:3].
  output logic [rtcd_pkg::OUT_USER_W-1:0] m_tuser,
  // Timeout register write.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rtcd_pkg::CFG_W-1:0]      cfg_data
);
  import rtcd_pkg::*;

  // Input register
  logic                 in_valid;
  logic                 in_level;
  logic [TIME_BITS-1:0] in_time;
  logic                 advance;

  // Decoder state
  logic [CFG_W-1:0]      timeout_ms;
  logic                  last_level;
  logic [TIME_BITS-1:0]  last_fall;
  logic                  pending_bit;
  logic [STORE_BITS-1:0] bit_store;
  logic [COUNT_W-1:0]    bit_count;
  held_time_t            held;
  logic                  pulse_led;
  logic                  good_led;
  logic                  error_led;

  // Next values
  logic                  pending_bit_next;
  logic [COUNT_W-1:0]    bit_count_next;
  held_time_t            held_next;
  logic                  pulse_led_next;
  logic                  good_led_next;
  logic                  error_led_next;
  frame_status_t         status_next;
  logic                  shift_en;

  edge_class_t cls;
  logic        frame_ok;
  held_time_t  decoded;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;

  // Input register; a new sample enters when it is empty or the last one moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_level <= s_tdata[0];
      in_time  <= s_tdata[TIME_BITS:1];
    end
  end

  rtcd_edge_class #(
    .TIME_BITS (TIME_BITS)
  ) u_edge (
    .level      (in_level),
    .now        (in_time),
    .last_level (last_level),
    .last_fall  (last_fall),
    .timeout_ms (timeout_ms),
    .cls        (cls)
  );

  rtcd_frame_check u_frame (
    .bits     (bit_store),
    .pending  (pending_bit),
    .count    (bit_count),
    .frame_ok (frame_ok),
    .decoded  (decoded)
  );

  // Event handling: bits, second count, frame result and LEDs.
  always_comb begin
    pending_bit_next = pending_bit;
    bit_count_next   = bit_count;
    held_next        = held;
    pulse_led_next   = pulse_led;
    good_led_next    = good_led;
    error_led_next   = error_led;
    status_next      = FS_NONE;
    shift_en         = 1'b0;
    if (cls.fall) pulse_led_next = 1'b1;
    if (cls.rise) pulse_led_next = 1'b0;
    case (cls.ev)
      EV_INVALID: begin
        good_led_next  = 1'b0;
        error_led_next = 1'b1;
      end
      EV_ZERO: pending_bit_next = 1'b0;
      EV_ONE:  pending_bit_next = 1'b1;
      EV_SECOND: begin
        shift_en = (bit_count < COUNT_W'(STORE_BITS));
        if (bit_count != COUNT_W'(COUNT_MAX)) bit_count_next = bit_count + COUNT_W'(1);
      end
      EV_MINUTE: begin
        bit_count_next = '0;
        if (frame_ok) begin
          held_next      = decoded;
          status_next    = FS_OK;
          good_led_next  = 1'b1;
          error_led_next = 1'b0;
        end else begin
          status_next    = FS_ERROR;
          good_led_next  = 1'b0;
          error_led_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control state and held time.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms   <= TIMEOUT_RESET;
      last_level   <= 1'b0;
      last_fall    <= '0;
      pending_bit  <= 1'b0;
      bit_count    <= '0;
      held.minute  <= '0;
      held.hour    <= '0;
      held.day     <= 5'd1;
      held.weekday <= 3'd7;
      held.month   <= 4'd1;
      held.year    <= 12'(YEAR_RESET);
      pulse_led    <= 1'b0;
      good_led     <= 1'b0;
      error_led    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) timeout_ms <= cfg_data;
      if (advance) begin
        last_level  <= in_level;
        if (cls.fall) last_fall <= in_time;
        pending_bit <= pending_bit_next;
        bit_count   <= bit_count_next;
        held        <= held_next;
        pulse_led   <= pulse_led_next;
        good_led    <= good_led_next;
        error_led   <= error_led_next;
      end
    end
  end

  // Bit store as a shift line: after a full minute the first bit sits at 0.
  always_ff @(posedge clk) begin
    if (advance && shift_en) begin
      bit_store <= {pending_bit, bit_store[STORE_BITS-1:1]};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser <= {status_next, cls.ev};
      m_tdata <= {2'b00, error_led_next, good_led_next, pulse_led_next,
                  held_next.year, held_next.month, held_next.weekday,
                  held_next.day, held_next.hour, held_next.minute};
    end
  end

  // A frame status comes with a minute mark and with nothing else.
  a_status_on_minute: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser[4:3] != FS_NONE) == (m_tuser[2:0] == EV_MINUTE)))
    else $error("frame status without minute mark");

  // The good and error LEDs are never lit together.
  a_led_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(good_led && error_led))
    else $error("good and error LEDs both on");

  // A minute mark always restarts the bit count.
  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && cls.ev == EV_MINUTE) |=> (bit_count == '0))
    else $error("bit count not cleared after minute mark");

  // A good frame is shown with the good LED on.
  a_ok_led: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[4:3] == FS_OK) |-> (m_tdata[36] && !m_tdata[37]))
    else $error("good frame without good LED");

endmodule

// ===== tb/rtcd_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcd_result_checker: result predictor and comparator for the decoder
// Watches the sample, result and timeout-write channels, keeps its own copy of
// the decoder state, works out the result of every accepted sample and checks
// each accepted result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module rtcd_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // tdata: level [0], time_ms [16:1], zero padding.
  input  logic [23:0]                     s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // tdata: minute, hour, day, weekday, month, year, pulse_led, good_led,
  // error_led, zero padding.
  input  logic [rtcd_pkg::OUT_DATA_W-1:0] m_tdata,
  // tuser: event_res [2:0], frame_status [4:3].
  input  logic [rtcd_pkg::OUT_USER_W-1:0] m_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rtcd_pkg::CFG_W-1:0]      cfg_data,
  output int                              fail_count,
  output int                              outstanding,
  output int                              results_seen,
  output int                              frames_ok,
  output int                              frames_bad,
  output int                              invalid_seen
);
  import rtcd_pkg::*;

  typedef struct packed {
    event_t        ev;
    frame_status_t fs;
    held_time_t    tm;
    logic          pulse;
    logic          good;
    logic          err;
  } report_t;

  // Predicted results waiting for the decoder to deliver them.
  report_t due_reports[$];

  // Shadow copy of the decoder state.
  logic [15:0]           timeout_ms;
  logic                  prev_level;
  logic [15:0]           fall_stamp;
  logic                  held_bit;
  logic [STORE_BITS-1:0] frame_bits;
  logic [COUNT_W-1:0]    sec_count;
  held_time_t            shown;
  logic                  led_pulse;
  logic                  led_good;
  logic                  led_error;

  int n_fail;
  int n_results;
  int n_ok;
  int n_bad;
  int n_invalid;

  // Value of a field coded with the weights 1, 2, 4, 8, 10, 20, 40, 80.
  function automatic int bcd_value(input logic [7:0] v);
    int s;
    s = 0;
    for (int k = 0; k < 8; k++) begin
      if (v[k]) s += (k < 4) ? (1 << k) : 10 * (1 << (k - 4));
    end
    return s;
  endfunction

  // Checks one complete frame (58 stored bits plus the parity bit still held)
  // and decodes it. Returns 1 for a good frame.
  function automatic logic frame_valid(input logic [58:0] fr, output held_time_t t);
    int off;
    int mi;
    int hr;
    int dy;
    int wd;
    int mo;
    int yr;
    t = '0;
    if ({fr[17], fr[18]} == 2'b01) off = 1;
    else if ({fr[17], fr[18]} == 2'b10) off = 0;
    else return 1'b0;
    if (!fr[20]) return 1'b0;
    // Even parity over minute, hour and date groups, parity bits included.
    if (^fr[28:21]) return 1'b0;
    if (^fr[35:29]) return 1'b0;
    if (^fr[58:36]) return 1'b0;
    mi = bcd_value({1'b0, fr[27:21]});
    hr = off + bcd_value({2'b0, fr[34:29]});
    dy = bcd_value({2'b0, fr[41:36]});
    wd = bcd_value({5'b0, fr[44:42]});
    mo = bcd_value({3'b0, fr[49:45]});
    yr = YEAR_BASE + bcd_value(fr[57:50]);
    if (mi > 59 || hr > 23) return 1'b0;
    if (dy == 0 || dy > 31 || wd == 0 || wd > 7) return 1'b0;
    if (mo == 0 || mo > 12 || yr > 2099) return 1'b0;
    t.minute  = 6'(mi);
    t.hour    = 5'(hr);
    t.day     = 5'(dy);
    t.weekday = 3'(wd);
    t.month   = 4'(mo);
    t.year    = 12'(yr);
    return 1'b1;
  endfunction

  // Advances the shadow state by one sample and returns the result it causes.
  function automatic report_t decode_sample(input logic lvl, input logic [15:0] stamp);
    logic [15:0]   el;
    event_t        ev;
    frame_status_t fs;
    held_time_t    t;
    report_t       r;
    el = stamp - fall_stamp;
    ev = EV_NONE;
    fs = FS_NONE;
    if (lvl == prev_level) begin
      if (el > timeout_ms) ev = EV_INVALID;
    end else if (!lvl) begin
      if (el >= SEC_MIN && el <= SEC_MAX) ev = EV_SECOND;
      else if (el >= MIN_MIN && el <= MIN_MAX) ev = EV_MINUTE;
      else ev = EV_INVALID;
      led_pulse  = 1'b1;
      fall_stamp = stamp;
    end else begin
      if (el >= ZERO_MIN && el <= ZERO_MAX) ev = EV_ZERO;
      else if (el >= ONE_MIN && el <= ONE_MAX) ev = EV_ONE;
      else ev = EV_INVALID;
      led_pulse = 1'b0;
    end
    prev_level = lvl;

    case (ev)
      EV_INVALID: begin
        led_good  = 1'b0;
        led_error = 1'b1;
        n_invalid++;
      end
      EV_ZERO: held_bit = 1'b0;
      EV_ONE:  held_bit = 1'b1;
      EV_SECOND: begin
        if (sec_count < STORE_BITS) frame_bits[sec_count] = held_bit;
        if (sec_count < COUNT_MAX) sec_count++;
      end
      EV_MINUTE: begin
        fs = FS_ERROR;
        if (sec_count == STORE_BITS) begin
          if (frame_valid({held_bit, frame_bits}, t)) fs = FS_OK;
        end
        if (fs == FS_OK) begin
          shown     = t;
          led_good  = 1'b1;
          led_error = 1'b0;
          n_ok++;
        end else begin
          led_good  = 1'b0;
          led_error = 1'b1;
          n_bad++;
        end
        sec_count = '0;
      end
      default: ;
    endcase

    r.ev    = ev;
    r.fs    = fs;
    r.tm    = shown;
    r.pulse = led_pulse;
    r.good  = led_good;
    r.err   = led_error;
    return r;
  endfunction

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst) begin
      timeout_ms     = TIMEOUT_RESET;
      prev_level     = 1'b0;
      fall_stamp     = '0;
      held_bit       = 1'b0;
      frame_bits     = '0;
      sec_count      = '0;
      shown          = '0;
      shown.day      = 5'd1;
      shown.weekday  = 3'd7;
      shown.month    = 4'd1;
      shown.year     = 12'(YEAR_RESET);
      led_pulse      = 1'b0;
      led_good       = 1'b0;
      led_error      = 1'b0;
      n_fail         = 0;
      n_results      = 0;
      n_ok           = 0;
      n_bad          = 0;
      n_invalid      = 0;
      due_reports.delete();
    end else begin
      // Compare a delivered result with the oldest prediction.
      if (m_tvalid && m_tready) begin
        got.ev    = event_t'(m_tuser[2:0]);
        got.fs    = frame_status_t'(m_tuser[4:3]);
        got.tm    = held_time_t'(m_tdata[34:0]);
        got.pulse = m_tdata[35];
        got.good  = m_tdata[36];
        got.err   = m_tdata[37];
        n_results++;
        if (due_reports.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("ERROR: result %0d arrived with no sample waiting for it", n_results);
        end else begin
          want = due_reports.pop_front();
          if (got.ev !== want.ev || got.fs !== want.fs ||
              got.tm.minute !== want.tm.minute || got.tm.hour !== want.tm.hour ||
              got.tm.day !== want.tm.day || got.tm.weekday !== want.tm.weekday ||
              got.tm.month !== want.tm.month || got.tm.year !== want.tm.year ||
              got.pulse !== want.pulse || got.good !== want.good ||
              got.err !== want.err) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("ERROR: result %0d got      ev=%0d fs=%0d %0d-%0d-%0d wd=%0d %0d:%0d leds=%b%b%b",
                       n_results, got.ev, got.fs, got.tm.year, got.tm.month, got.tm.day,
                       got.tm.weekday, got.tm.hour, got.tm.minute,
                       got.pulse, got.good, got.err);
              $display("       result %0d expected ev=%0d fs=%0d %0d-%0d-%0d wd=%0d %0d:%0d leds=%b%b%b",
                       n_results, want.ev, want.fs, want.tm.year, want.tm.month, want.tm.day,
                       want.tm.weekday, want.tm.hour, want.tm.minute,
                       want.pulse, want.good, want.err);
            end
          end
        end
      end

      // Every accepted sample causes exactly one result.
      if (s_tvalid && s_tready) due_reports.push_back(decode_sample(s_tdata[0], s_tdata[16:1]));

      if (cfg_valid && cfg_ready) timeout_ms = cfg_data;
    end

    fail_count   <= n_fail;
    outstanding  <= due_reports.size();
    results_seen <= n_results;
    frames_ok    <= n_ok;
    frames_bad   <= n_bad;
    invalid_seen <= n_invalid;
  end

endmodule

// ===== tb/tb_radio_time_code_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radio_time_code_decoder: regression bench for the time-code decoder
// Drives receiver samples as pulse trains of whole minute frames, good and
// damaged, mixed with stray samples and window-edge pulses, under several
// timeout settings, with random stalls on both streams. A separate checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_radio_time_code_decoder;
  import rtcd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_SAMPLES  = 170;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data  = '0;

  int fail_count;
  int outstanding;
  int results_seen;
  int frames_ok;
  int frames_bad;
  int invalid_seen;

  // Sender-side view of the line: what the decoder has been shown so far.
  logic        tb_level     = 1'b0;
  logic [15:0] tb_last_fall = '0;
  logic [15:0] tb_timeout   = TIMEOUT_RESET;
  logic        steady       = 1'b0;
  int          n_sent       = 0;
  int          n_settings   = 1;
  int          stall_left   = 0;
  int          idle_cycles  = 0;

  always #5 clk = ~clk;

  radio_time_code_decoder #(
    .TIME_BITS(16)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  rtcd_result_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .frames_ok    (frames_ok),
    .frames_bad   (frames_bad),
    .invalid_seen (invalid_seen)
  );

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A value inside a timing window, with the window ends favored.
  function automatic int in_window(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  function automatic logic [7:0] to_bcd(input int v);
    return 8'((v / 10) * 16 + v % 10);
  endfunction

  // Builds the 58 data bits plus the trailing date parity of one minute.
  function automatic logic [58:0] make_frame(input logic flawed);
    logic [58:0] f;
    logic        winter;
    logic [7:0]  v;
    int          mode;
    f[31:0]  = $urandom;
    f[58:32] = 27'($urandom);
    winter   = 1'($urandom_range(0, 1));
    f[17]    = ~winter;
    f[18]    = winter;
    f[20]    = 1'b1;
    v = to_bcd($urandom_range(0, 59));
    f[27:21] = v[6:0];
    v = to_bcd(winter ? $urandom_range(0, 22) : $urandom_range(0, 23));
    f[34:29] = v[5:0];
    v = to_bcd($urandom_range(1, 31));
    f[41:36] = v[5:0];
    f[44:42] = 3'($urandom_range(1, 7));
    v = to_bcd($urandom_range(1, 12));
    f[49:45] = v[4:0];
    f[57:50] = to_bcd($urandom_range(0, 99));
    mode = flawed ? $urandom_range(0, 3) : -1;
    // Damage that keeps the parity consistent.
    if (mode == 1) f[57:21] = 37'({$urandom, $urandom});
    if (mode == 2) f[18] = f[17];
    if (mode == 3) f[20] = 1'b0;
    f[28] = ^f[27:21];
    f[35] = ^f[34:29];
    f[58] = ^f[57:36];
    // Damage after the parity is set: one flipped bit anywhere.
    if (mode == 0) f[$urandom_range(0, 58)] ^= 1'b1;
    return f;
  endfunction

  // Offers one sample and waits for its request to be taken.
  task automatic send_sample(input logic lvl, input logic [15:0] stamp);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, stamp, lvl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!lvl && tb_level) tb_last_fall = stamp;
    tb_level = lvl;
    n_sent++;
  endtask

  // One carrier drop: rise after the bit length, fall a second (or two) on,
  // with an occasional sample of unchanged level in between.
  task automatic emit_pulse(input logic b, input logic closing);
    int          rise_len;
    int          period;
    logic [15:0] base;
    base     = tb_last_fall;
    rise_len = b ? in_window(ONE_MIN, ONE_MAX) : in_window(ZERO_MIN, ZERO_MAX);
    period   = closing ? in_window(MIN_MIN, MIN_MAX) : in_window(SEC_MIN, SEC_MAX);
    if ($urandom_range(0, 7) == 0)
      send_sample(1'b0, 16'(base + $urandom_range(1, rise_len - 1)));
    send_sample(1'b1, 16'(base + rise_len));
    if ($urandom_range(0, 7) == 0)
      send_sample(1'b1, 16'(base + $urandom_range(rise_len + 1, period - 1)));
    send_sample(1'b0, 16'(base + period));
  endtask

  // Synchronizes on a minute mark, then sends one frame of pulses.
  task automatic send_frame(input logic flawed);
    logic [58:0] f;
    int          nsec;
    logic        b;
    f    = make_frame(flawed);
    nsec = 59;
    if (flawed && $urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 2))
        0:       nsec = 58;
        1:       nsec = 60;
        default: nsec = 70;
      endcase
    end
    if (tb_level) send_sample(1'b0, 16'(tb_last_fall + in_window(MIN_MIN, MIN_MAX)));
    else emit_pulse(1'($urandom_range(0, 1)), 1'b1);
    for (int i = 0; i < nsec; i++) begin
      if (i == nsec - 1) b = f[58];
      else if (i < STORE_BITS) b = f[i];
      else b = 1'($urandom_range(0, 1));
      emit_pulse(b, i == nsec - 1);
    end
  endtask

  // Stray activity: random samples, pulses on the window edges, and samples
  // of unchanged level right at and past the timeout.
  task automatic send_noise();
    int rise_len;
    int period;
    case ($urandom_range(0, 2))
      0: send_sample(1'($urandom_range(0, 1)), 16'($urandom));
      1: begin
        case ($urandom_range(0, 7))
          0:       rise_len = ZERO_MIN - 1;
          1:       rise_len = ZERO_MIN;
          2:       rise_len = ZERO_MAX;
          3:       rise_len = ZERO_MAX + 1;
          4:       rise_len = ONE_MIN - 1;
          5:       rise_len = ONE_MIN;
          6:       rise_len = ONE_MAX;
          default: rise_len = ONE_MAX + 1;
        endcase
        case ($urandom_range(0, 7))
          0:       period = SEC_MIN - 1;
          1:       period = SEC_MIN;
          2:       period = SEC_MAX;
          3:       period = SEC_MAX + 1;
          4:       period = MIN_MIN - 1;
          5:       period = MIN_MIN;
          6:       period = MIN_MAX;
          default: period = MIN_MAX + 1;
        endcase
        if (tb_level) send_sample(1'b0, 16'(tb_last_fall + period));
        send_sample(1'b1, 16'(tb_last_fall + rise_len));
        send_sample(1'b0, 16'(tb_last_fall + period));
      end
      default: begin
        send_sample(tb_level, 16'(tb_last_fall + tb_timeout));
        send_sample(tb_level, 16'(tb_last_fall + tb_timeout + 1));
      end
    endcase
  endtask

  // Writes the timeout once the decoder has delivered everything.
  task automatic set_timeout(input logic [15:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    tb_timeout = value;
    n_settings++;
  endtask

  // Result side: random stalls, with calm stretches that take every result.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (steady || $urandom_range(0, 3) != 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // Watchdog on cycles in which no request moves on any channel.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase_end;
    int r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: timeout boundary, window edges, minute marks that end a short frame
    // and are rejected, and elapsed times across the wrap of the time base.
    send_sample(1'b0, 16'd0);
    send_sample(1'b0, 16'd3000);
    send_sample(1'b0, 16'd3001);
    send_sample(1'b1, 16'd69);
    send_sample(1'b0, 16'd900);
    send_sample(1'b1, 16'd970);
    send_sample(1'b0, 16'd2000);
    send_sample(1'b1, 16'd2130);
    send_sample(1'b0, 16'd3101);
    send_sample(1'b1, 16'd3232);
    send_sample(1'b0, 16'd4000);
    send_sample(1'b1, 16'd4170);
    send_sample(1'b0, 16'd5900);
    send_sample(1'b1, 16'd6130);
    send_sample(1'b0, 16'd8000);
    send_sample(1'b1, 16'd8231);
    send_sample(1'b0, 16'd10101);
    send_sample(1'b1, 16'd10270);
    send_sample(1'b0, 16'd65535);
    send_sample(1'b1, 16'd99);
    send_sample(1'b0, 16'd999);
    send_sample(1'b1, 16'd65535);

    // Random phases, one per timeout setting; the first keeps the reset value.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       ;
        1:       set_timeout(16'hFFFF);
        2:       set_timeout(16'h0000);
        3:       set_timeout(16'($urandom));
        4:       set_timeout(16'($urandom_range(150, 2200)));
        default: set_timeout(TIMEOUT_RESET);
      endcase
      phase_end = n_sent + PHASE_SAMPLES;
      while (n_sent < phase_end) begin
        steady = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 72) send_frame(1'b0);
        else if (r < 88) send_frame(1'b1);
        else repeat ($urandom_range(3, 12)) send_noise();
      end
    end

    // Drain: every predicted result must come back.
    steady = 1'b0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d samples under %0d timeout settings; %0d results checked.",
             n_sent, n_settings, results_seen);
    $display("Minute frames decoded good: %0d, rejected: %0d; invalid events: %0d.",
             frames_ok, frames_bad, invalid_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rtcd_pkg.sv
hw/rtl/rtcd_edge_class.sv
hw/rtl/rtcd_frame_check.sv
hw/rtl/radio_time_code_decoder.sv
tb/rtcd_result_checker.sv
tb/tb_radio_time_code_decoder.sv
